### hw/rtl/trapezoid_energy_estimator_unit_assert.svh
// Assertion macros used by the estimator controller.
`ifndef TRAPEZOID_ENERGY_ESTIMATOR_UNIT_ASSERT_SVH
`define TRAPEZOID_ENERGY_ESTIMATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TEEU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TEEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/teeu_pkg.sv
package teeu_pkg;

  // Field widths.
  localparam int CurW     = 16;
  localparam int TimeW    = 32;
  localparam int PowerW   = 30;
  localparam int EnergyW  = 64;
  localparam int CountW   = 32;
  localparam int VoltW    = 16;
  localparam int PfW      = 16;
  localparam int StandbyW = 20;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Fixed-point scaling: Q4 volts times Q15 power factor.
  localparam int PowerShift = 19;

  // Register reset values.
  localparam logic [VoltW-1:0]    VoltReset   = 16'd3680;
  localparam logic [PfW-1:0]      PfOne       = 16'd32768;
  localparam logic [StandbyW-1:0] StandbyReset = 20'd0;
  localparam logic [TimeW-1:0]    MaxGapReset = 32'd60000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE  = 3'd0,
    CFG_VOLTAGE = 3'd1,
    CFG_PF      = 3'd2,
    CFG_STANDBY = 3'd3,
    CFG_MAX_GAP = 3'd4
  } cfg_idx_t;

  // Input word.
  typedef struct packed {
    logic             mode;
    logic [CurW-1:0]  current_ma;
    logic             current_ok;
    logic             state_known;
    logic             unit_on;
    logic [TimeW-1:0] now_ms;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic               accepted;
    logic [PowerW-1:0]  power_mw;
    logic               power_ok;
    logic               energy_ok;
    logic [EnergyW-1:0] energy_uj;
    logic [CountW-1:0]  sample_total;
    logic [CountW-1:0]  integrated_total;
    logic [CountW-1:0]  skipped_total;
    logic [TimeW-1:0]   last_time_ms;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_VI,
    ST_MUL_PF,
    ST_MUL_E,
    ST_UPD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_vi;
    logic mul_pf;
    logic mul_e;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/trapezoid_energy_estimator_unit.sv
// Trapezoid energy estimator. Each input word is either a current sample or a window
// restart; it yields exactly one result word reporting the state after it. Power in mW
// is current_ma * voltage_q4 * pf_q15 / 2^19, floored to standby_mw when the unit is
// known off, and energy in uJ grows by (previous + new power) * elapsed ms / 2,
// saturating at 2^64-1. The block works on one word at a time: accept, the
// current-times-voltage multiply, the power-factor multiply, the trapezoid multiply and
// the commit run in that order; the commit waits while the output register holds an
// untaken result. The user must write configuration through cfg_we/cfg_index/cfg_wdata
// only while the block is idle, which the block does not enforce; invalid values are ignored.
module trapezoid_energy_estimator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  teeu_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output teeu_pkg::out_word_t           out_data,
  input  logic                          cfg_we,
  input  logic [teeu_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [teeu_pkg::CfgDataW-1:0] cfg_wdata
);
  import teeu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  teeu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, state and output register.
  teeu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/teeu_dp.sv
module teeu_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  teeu_pkg::cmd_t                  cmd,
  output teeu_pkg::sts_t                  sts,
  input  teeu_pkg::in_word_t              in_data,
  input  logic                            cfg_we,
  input  logic [teeu_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [teeu_pkg::CfgDataW-1:0]   cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_stall,
  output teeu_pkg::out_word_t             out_data
);
  import teeu_pkg::*;

  localparam int Prod1W = CurW + VoltW;
  localparam int Prod2W = Prod1W + PfW;
  localparam int SumW   = PowerW + 1;
  localparam int IncW   = SumW + TimeW;
  localparam int HalfW  = IncW - 1;

  // Configuration registers.
  logic                enable_r;
  logic [VoltW-1:0]    voltage_r;
  logic [PfW-1:0]      pf_r;
  logic [StandbyW-1:0] standby_r;
  logic [TimeW-1:0]    max_gap_r;

  // Estimator state.
  logic [PowerW-1:0]  prev_power_r, prev_power_nxt;
  logic [EnergyW-1:0] energy_r, energy_nxt;
  logic [TimeW-1:0]   prev_time_r, prev_time_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic               power_flag_r, power_flag_nxt;
  logic               energy_flag_r, energy_flag_nxt;
  logic [CountW-1:0]  sample_cnt_r, sample_cnt_nxt;
  logic [CountW-1:0]  integ_cnt_r, integ_cnt_nxt;
  logic [CountW-1:0]  skip_cnt_r, skip_cnt_nxt;
  logic               accepted_nxt;

  // Working registers.
  in_word_t          in_r;
  logic [Prod1W-1:0] prod1_r;
  logic [PowerW-1:0] pwr_r;
  logic [TimeW-1:0]  dt_r;
  logic [IncW-1:0]   inc_r;

  // Output register.
  logic      out_valid_r;
  out_word_t out_data_r;

  logic [Prod2W-1:0]  prod2;
  logic [PowerW-1:0]  pwr_raw;
  logic [PowerW-1:0]  pwr_clamp;
  logic [SumW-1:0]    pwr_sum;
  logic [HalfW-1:0]   inc_half;
  logic [EnergyW:0]   energy_sum;
  logic               dt_nonzero;
  logic               dt_in_range;

  // Configuration writes; out-of-range values leave the register alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b1;
      voltage_r <= VoltReset;
      pf_r      <= PfOne;
      standby_r <= StandbyReset;
      max_gap_r <= MaxGapReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:  enable_r <= cfg_wdata[0];
        CFG_VOLTAGE: begin
          if (cfg_wdata[VoltW-1:0] != '0) voltage_r <= cfg_wdata[VoltW-1:0];
        end
        CFG_PF: begin
          if (cfg_wdata[PfW-1:0] != '0 && cfg_wdata[PfW-1:0] <= PfOne) begin
            pf_r <= cfg_wdata[PfW-1:0];
          end
        end
        CFG_STANDBY: standby_r <= cfg_wdata[StandbyW-1:0];
        CFG_MAX_GAP: begin
          if (cfg_wdata[TimeW-1:0] != '0) max_gap_r <= cfg_wdata[TimeW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Power: second multiply, scale, and standby floor while known off.
  always_comb begin
    prod2   = prod1_r * {{(Prod2W-PfW){1'b0}}, pf_r};
    pwr_raw = PowerW'(prod2[Prod2W-1:PowerShift]);
    pwr_clamp = pwr_raw;
    if (in_r.state_known && !in_r.unit_on &&
        pwr_raw < {{(PowerW-StandbyW){1'b0}}, standby_r}) begin
      pwr_clamp = {{(PowerW-StandbyW){1'b0}}, standby_r};
    end
  end

  assign pwr_sum = {1'b0, prev_power_r} + {1'b0, pwr_r};

  // Pipeline of the shared arithmetic steps.
  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.mul_vi) begin
      prod1_r <= {{(Prod1W-CurW){1'b0}}, in_r.current_ma} *
                 {{(Prod1W-VoltW){1'b0}}, voltage_r};
    end
    if (cmd.mul_pf) begin
      pwr_r <= pwr_clamp;
      dt_r  <= in_r.now_ms - prev_time_r;
    end
    if (cmd.mul_e) begin
      inc_r <= {{TimeW{1'b0}}, pwr_sum} * {{SumW{1'b0}}, dt_r};
    end
  end

  // Trapezoid increment and saturating energy add.
  assign inc_half    = inc_r[IncW-1:1];
  assign energy_sum  = {1'b0, energy_r} + {{(EnergyW+1-HalfW){1'b0}}, inc_half};
  assign dt_nonzero  = (dt_r != '0);
  assign dt_in_range = (dt_r <= max_gap_r);

  // Next state at commit.
  always_comb begin
    prev_power_nxt  = prev_power_r;
    energy_nxt      = energy_r;
    prev_time_nxt   = prev_time_r;
    have_prev_nxt   = have_prev_r;
    power_flag_nxt  = power_flag_r;
    energy_flag_nxt = energy_flag_r;
    sample_cnt_nxt  = sample_cnt_r;
    integ_cnt_nxt   = integ_cnt_r;
    skip_cnt_nxt    = skip_cnt_r;
    accepted_nxt    = 1'b0;
    if (in_r.mode) begin
      have_prev_nxt  = 1'b0;
      power_flag_nxt = 1'b0;
      prev_time_nxt  = '0;
    end else if (enable_r && in_r.current_ok) begin
      if (have_prev_r) begin
        if (dt_nonzero && dt_in_range) begin
          energy_nxt    = energy_sum[EnergyW] ? '1 : energy_sum[EnergyW-1:0];
          integ_cnt_nxt = integ_cnt_r + 1'b1;
        end else if (!dt_in_range) begin
          skip_cnt_nxt = skip_cnt_r + 1'b1;
        end
      end
      prev_power_nxt  = pwr_r;
      power_flag_nxt  = 1'b1;
      energy_flag_nxt = 1'b1;
      have_prev_nxt   = 1'b1;
      prev_time_nxt   = in_r.now_ms;
      sample_cnt_nxt  = sample_cnt_r + 1'b1;
      accepted_nxt    = 1'b1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_power_r  <= '0;
      energy_r      <= '0;
      prev_time_r   <= '0;
      have_prev_r   <= 1'b0;
      power_flag_r  <= 1'b0;
      energy_flag_r <= 1'b0;
      sample_cnt_r  <= '0;
      integ_cnt_r   <= '0;
      skip_cnt_r    <= '0;
    end else if (cmd.commit) begin
      prev_power_r  <= prev_power_nxt;
      energy_r      <= energy_nxt;
      prev_time_r   <= prev_time_nxt;
      have_prev_r   <= have_prev_nxt;
      power_flag_r  <= power_flag_nxt;
      energy_flag_r <= energy_flag_nxt;
      sample_cnt_r  <= sample_cnt_nxt;
      integ_cnt_r   <= integ_cnt_nxt;
      skip_cnt_r    <= skip_cnt_nxt;
    end
  end

  // Output register: filled at commit, emptied when the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.accepted         <= accepted_nxt;
      out_data_r.power_mw         <= power_flag_nxt ? prev_power_nxt : '0;
      out_data_r.power_ok         <= power_flag_nxt;
      out_data_r.energy_ok        <= energy_flag_nxt;
      out_data_r.energy_uj        <= energy_nxt;
      out_data_r.sample_total     <= sample_cnt_nxt;
      out_data_r.integrated_total <= integ_cnt_nxt;
      out_data_r.skipped_total    <= skip_cnt_nxt;
      out_data_r.last_time_ms     <= prev_time_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

### hw/rtl/teeu_ctrl.sv
`include "trapezoid_energy_estimator_unit_assert.svh"

module teeu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  teeu_pkg::sts_t sts,
  output teeu_pkg::cmd_t cmd
);
  import teeu_pkg::*;

  state_t state_r, state_nxt;
  logic   take;

  assign take = in_valid && !in_stall;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL_VI;
      ST_MUL_VI: state_nxt = ST_MUL_PF;
      ST_MUL_PF: state_nxt = ST_MUL_E;
      ST_MUL_E:  state_nxt = ST_UPD;
      ST_UPD:    if (!sts.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output decode.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MUL_VI: cmd.mul_vi = 1'b1;
      ST_MUL_PF: cmd.mul_pf = 1'b1;
      ST_MUL_E:  cmd.mul_e  = 1'b1;
      ST_UPD:    cmd.commit = !sts.out_busy;
      default: ;
    endcase
  end

  // An accepted word always starts the multiply sequence.
  `TEEU_ASSERT_NEXT(a_take_starts, take, state_r == ST_MUL_VI, "accept did not start sequence")
  // A full output register holds the sequencer in the commit state.
  `TEEU_ASSERT_NEXT(a_upd_holds, state_r == ST_UPD && sts.out_busy, state_r == ST_UPD, "commit state left while output full")
  // Commit never overwrites a result that is still waiting.
  `TEEU_ASSERT_SAME(a_commit_free, cmd.commit, !sts.out_busy, "commit while output full")

endmodule
